[src/bqm_pkg.sv]
// Shared types and constants for the byte queue with pop-minimum.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package bqm_pkg;

  localparam int BQM_CAPACITY = 10;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_POP_MIN = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

endpackage

[src/bqm_cmp_unit.sv]
// Signed compare unit used by the scan of the queue.
// Decides whether the candidate replaces the current best entry.
`timescale 1ns / 1ps

module bqm_cmp_unit (
  input  logic signed [7:0] cand,
  input  logic signed [7:0] best,
  input  logic              best_valid,
  output logic              take
);

  // strict less-than keeps the earliest minimum
  assign take = !best_valid || (cand < best);

endmodule

[src/byte_queue_with_pop_min.sv]
// Top level: circular byte queue with push, pop, peek, pop-minimum and clear.
// Depends on bqm_pkg and bqm_cmp_unit.
//
//   channel  signals                           direction
//   in       in_valid in_stall opcode           request transaction
//            push_value
//   out      out_valid out_stall value status   result transaction
//            count queue_empty is_full
//
// Push, clear, unused codes and empty cases go straight to the result; peek and pop read the head.
// Pop minimum scans all N entries for the minimum, then compacts the entries behind it:
// one read per cycle for the scan, one read and one write per cycle for the compaction.
// Reset leaves the queue empty; storage contents are not cleared.
// A held result does not block the next request; its result waits for the output register.
`timescale 1ns / 1ps

module byte_queue_with_pop_min #(
  parameter int CAPACITY = bqm_pkg::BQM_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic signed [7:0] push_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] value,
  output logic [1:0]        status,
  output logic [3:0]        count,
  output logic              queue_empty,
  output logic              is_full
);

  import bqm_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] LAST = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == LAST) return '0;
    return p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    if (p == '0) return LAST;
    return p - PW'(1);
  endfunction

  state_t state, state_next;

  logic [PW-1:0]     head, tail;
  logic [CW-1:0]     entry_count;
  logic [CW+3:0]     count_wide;
  op_t               op_q;
  logic [PW-1:0]     rd_ptr, wr_ptr, pend_addr, best_addr;
  logic [CW-1:0]     rd_left;
  logic              pend;
  logic signed [7:0] best_val;
  logic              best_valid;
  logic signed [7:0] res_value;
  status_t           res_status;
  logic              take;

  logic signed [7:0] mem [CAPACITY];
  logic signed [7:0] rd_data;
  logic              mem_re, mem_we;
  logic [PW-1:0]     mem_raddr, mem_waddr;
  logic signed [7:0] mem_wdata;

  logic in_accept, load_out, scan_done, shift_done, full_now;

  assign in_accept  = in_valid && !in_stall;
  assign full_now   = (entry_count == FULL_COUNT);
  assign scan_done  = (rd_left == '0) && !pend;
  assign shift_done = (rd_ptr == tail) && !pend;
  assign count_wide = {4'b0, entry_count};

  bqm_cmp_unit u_cmp (
    .cand       (rd_data),
    .best       (best_val),
    .best_valid (best_valid),
    .take       (take)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (opcode)
            OP_POP, OP_PEEK, OP_POP_MIN: begin
              state_next = (entry_count != '0) ? S_SCAN : S_FINISH;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) state_next = (op_q == OP_POP_MIN) ? S_SHIFT : S_FINISH;
      end
      S_SHIFT: begin
        if (shift_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mem_re    = 1'b0;
    mem_raddr = rd_ptr;
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = rd_data;
    load_out  = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_accept && opcode == OP_PUSH && !full_now) begin
          mem_we    = 1'b1;
          mem_waddr = tail;
          mem_wdata = push_value;
        end
      end
      S_SCAN: begin
        mem_re = (rd_left != '0);
      end
      S_SHIFT: begin
        mem_re = (rd_ptr != tail);
        mem_we = pend;
      end
      S_FINISH: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      tail        <= '0;
      entry_count <= '0;
      pend        <= 1'b0;
      rd_left     <= '0;
      best_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= load_out || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            pend       <= 1'b0;
            best_valid <= 1'b0;
            rd_left    <= (opcode == OP_POP_MIN) ? entry_count : CW'(1);
            case (opcode)
              OP_PUSH: begin
                if (!full_now) begin
                  tail        <= ptr_inc(tail);
                  entry_count <= entry_count + CW'(1);
                end
              end
              OP_CLEAR: begin
                head        <= '0;
                tail        <= '0;
                entry_count <= '0;
              end
              default: begin
                head <= head;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            rd_left <= rd_left - CW'(1);
            pend    <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && take) best_valid <= 1'b1;
          if (scan_done && op_q == OP_POP) begin
            head        <= ptr_inc(head);
            entry_count <= entry_count - CW'(1);
          end
        end
        S_SHIFT: begin
          pend <= mem_re;
          if (shift_done) begin
            tail        <= ptr_dec(tail);
            entry_count <= entry_count - CW'(1);
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          op_q       <= op_t'(opcode);
          rd_ptr     <= head;
          res_value  <= '0;
          res_status <= ST_OK;
          case (opcode)
            OP_PUSH: begin
              if (full_now) res_status <= ST_FULL;
            end
            OP_POP, OP_PEEK, OP_POP_MIN: begin
              if (entry_count == '0) res_status <= ST_EMPTY;
            end
            default: begin
              res_status <= ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (mem_re) begin
          rd_ptr    <= ptr_inc(rd_ptr);
          pend_addr <= rd_ptr;
        end
        if (pend && take) begin
          best_val  <= rd_data;
          best_addr <= pend_addr;
        end
        if (scan_done) begin
          res_value <= best_val;
          rd_ptr    <= ptr_inc(best_addr);
          wr_ptr    <= best_addr;
        end
      end
      S_SHIFT: begin
        if (mem_re) begin
          rd_ptr    <= ptr_inc(rd_ptr);
          wr_ptr    <= rd_ptr;
          pend_addr <= wr_ptr;
        end
      end
      S_FINISH: begin
        if (load_out) begin
          value       <= res_value;
          status      <= res_status;
          count       <= count_wide[3:0];
          queue_empty <= (entry_count == '0);
          is_full     <= full_now;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

[src/bqm_checker.sv]
// Port-level checks for byte_queue_with_pop_min, attached by bind.
// Depends on bqm_pkg for the status codes.
`timescale 1ns / 1ps

module bqm_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [2:0]        opcode,
  input logic signed [7:0] push_value,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [7:0] value,
  input logic [1:0]        status,
  input logic [3:0]        count,
  input logic              queue_empty,
  input logic              is_full
);

  import bqm_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(push_value))
    else $error("request transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status)
                               && $stable(count))
    else $error("result transaction changed while stalled");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && queue_empty |-> count == 4'd0 && !is_full)
    else $error("empty flag disagrees with count");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> is_full && value == 8'sd0)
    else $error("refused push without full queue");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> queue_empty && value == 8'sd0)
    else $error("empty status on non-empty queue");

endmodule

bind byte_queue_with_pop_min bqm_checker u_bqm_checker (.*);
